/* rtl/sharpen_conv3x3_stream_assert.svh */
// Assertion macros for the sharpen filter RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef SHARPEN_CONV3X3_STREAM_ASSERT_SVH
`define SHARPEN_CONV3X3_STREAM_ASSERT_SVH

// same-cycle implication
`define SHC3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHC3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/shc3_pkg.sv */
// Package for the 3x3 sharpen filter: word types, register codes, fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package shc3_pkg;

	localparam int IW_BITS     = 11;
	localparam int IH_BITS     = 13;
	localparam int ROW_BITS    = 14;
	localparam int FILT_BITS   = 12;
	localparam int PIX_IN_BITS = 8;
	localparam int REG_BITS    = 1;
	localparam int CFG_BITS    = 13;

	localparam logic [IW_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IH_BITS-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [REG_BITS-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [PIX_IN_BITS-1:0] pixel;
	} pix_word_t;

	typedef struct packed {
		logic signed [FILT_BITS-1:0] filtered;
		logic                        end_of_frame;
	} res_word_t;

	typedef struct packed {
		logic pass;
		logic emit;
		logic up;
		logic down;
		logic left;
		logic right;
		logic eof;
	} pos_flags_t;

endpackage

/* rtl/shc3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`timescale 1ns / 1ps

module shc3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/shc3_pos.sv */
// Raster position tracker: column and row counters, border and output flags.
// Depends on shc3_pkg and sharpen_conv3x3_stream_assert.svh.
`timescale 1ns / 1ps
`include "sharpen_conv3x3_stream_assert.svh"

module shc3_pos #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            adv,
	input  logic [shc3_pkg::IW_BITS-1:0]    image_width,
	input  logic [shc3_pkg::IH_BITS-1:0]    image_height,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output shc3_pkg::pos_flags_t            flags
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = CW + 1;
	localparam int RB = shc3_pkg::ROW_BITS;

	logic [EW-1:0]                   eff_w;
	logic [shc3_pkg::IH_BITS-1:0]    eff_h;
	logic [CW-1:0]                   col_q;
	logic [RB-1:0]                   row_q;
	logic [EW-1:0]                   col_inc;
	logic [RB-1:0]                   h_x;
	logic [RB-1:0]                   h_p1;
	logic                            c0;
	logic                            last;

	always_comb begin
		if (image_width == '0) begin
			eff_w = EW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(image_width);
		end
	end

	assign eff_h   = (image_height == '0) ? shc3_pkg::IH_BITS'(1) : image_height;
	assign col_inc = EW'(col_q) + EW'(1);
	assign h_x     = RB'(eff_h);
	assign h_p1    = h_x + RB'(1);
	assign c0      = (col_q == '0);
	assign last    = c0 && (row_q >= h_p1);
	assign col     = col_q;

	always_comb begin
		flags.pass  = row_q < h_x;
		flags.emit  = (row_q >= RB'(2)) || ((row_q == RB'(1)) && !c0);
		flags.up    = c0 ? (row_q >= RB'(3)) : (row_q >= RB'(2));
		flags.down  = c0 ? (row_q <= h_x) : (row_q < h_x);
		flags.left  = c0 ? (eff_w > EW'(1)) : (col_q >= CW'(2));
		flags.right = !c0 && (EW'(col_q) < eff_w);
		flags.eof   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= row_q + RB'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	`SHC3_ASSERT_NEXT(a_frame_wrap, adv && !clr && last, col_q == '0 && row_q == '0, "no frame wrap")
	`SHC3_ASSERT_NOW(a_col_range, 1'b1, EW'(col_q) < eff_w, "column beyond image width")
	`SHC3_ASSERT_NOW(a_row_range, 1'b1, row_q <= h_p1, "row beyond drain row")

endmodule

/* rtl/shc3_win.sv */
// Neighborhood window and sharpen kernel: holds the up, down, left and center taps
// and forms 5*center - up - down - left - right, the right tap taken from mid_in. Depends on shc3_pkg.
`timescale 1ns / 1ps

module shc3_win #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  shift,
	input  logic [PIXEL_BITS-1:0]                 up_in,
	input  logic [PIXEL_BITS-1:0]                 mid_in,
	input  logic [PIXEL_BITS-1:0]                 dn_in,
	input  shc3_pkg::pos_flags_t                  flags,
	output logic signed [shc3_pkg::FILT_BITS-1:0] filtered
);

	localparam int SW  = PIXEL_BITS + 4;
	localparam int SXW = (SW > shc3_pkg::FILT_BITS) ? SW : shc3_pkg::FILT_BITS;

	logic [PIXEL_BITS-1:0] up_q;
	logic [PIXEL_BITS-1:0] dn_q;
	logic [PIXEL_BITS-1:0] lft_q;
	logic [PIXEL_BITS-1:0] ctr_q;
	logic [SW-1:0]         ctr_x;
	logic [SW-1:0]         up_x;
	logic [SW-1:0]         dn_x;
	logic [SW-1:0]         lft_x;
	logic [SW-1:0]         rgt_x;
	logic signed [SW-1:0]  sum;
	logic signed [SXW-1:0] sum_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q  <= '0;
			dn_q  <= '0;
			lft_q <= '0;
			ctr_q <= '0;
		end else if (shift) begin
			up_q  <= up_in;
			dn_q  <= dn_in;
			lft_q <= ctr_q;
			ctr_q <= mid_in;
		end
	end

	assign ctr_x = SW'(ctr_q);
	assign up_x  = flags.up    ? SW'(up_q)   : '0;
	assign dn_x  = flags.down  ? SW'(dn_q)   : '0;
	assign lft_x = flags.left  ? SW'(lft_q)  : '0;
	assign rgt_x = flags.right ? SW'(mid_in) : '0;

	assign sum      = (ctr_x << 2) + ctr_x - up_x - dn_x - lft_x - rgt_x;
	assign sum_x    = SXW'(sum);
	assign filtered = $signed(sum_x[shc3_pkg::FILT_BITS-1:0]);

endmodule

/* rtl/sharpen_conv3x3_stream.sv */
// Streaming 3x3 sharpen filter with zero padding, top level.
// Depends on shc3_pkg, shc3_pos, shc3_ram, shc3_win.
//
// Usage:
//   pix channel (pix_valid/pix_ready/pix_data) takes one word per raster
//   position: a pixel, or a flush word. After a frame's last pixel send
//   width+1 flush words to drain it. res channel (res_valid/res_ready/
//   res_data) gives the filtered value, with end_of_frame on the frame's
//   last pixel. The first width+1 words of a frame give no result.
//   wr_en/wr_index/wr_data set image_width and image_height; a write also
//   restarts the raster position. Write only while the block is idle.
// Throughput: one word per cycle while res is not stalled. Line stores are read
//   on accept and written as the word leaves the first stage, with a bypass for back-to-back use of an entry.
// Ordering: the result for pixel p passes the first-stage and output registers
//   after the word at raster position p + width + 1 is accepted.
// Reset: position, window and valid flags clear at once; line stores need no
//   clearing. When res_ready is low the result holds in the output register;
//   one more word may enter the first stage, then pix_ready drops.
`timescale 1ns / 1ps

module sharpen_conv3x3_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  shc3_pkg::pix_word_t              pix_data,
	output logic                             res_valid,
	input  logic                             res_ready,
	output shc3_pkg::res_word_t              res_data,
	input  logic                             wr_en,
	input  logic [shc3_pkg::REG_BITS-1:0]    wr_index,
	input  logic [shc3_pkg::CFG_BITS-1:0]    wr_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int KB = (PIXEL_BITS < shc3_pkg::PIX_IN_BITS) ? PIXEL_BITS : shc3_pkg::PIX_IN_BITS;

	logic [shc3_pkg::IW_BITS-1:0]        width_q;
	logic [shc3_pkg::IH_BITS-1:0]        height_q;
	logic                                accept;
	logic                                adv1;
	logic [CW-1:0]                       col;
	shc3_pkg::pos_flags_t                flags;
	logic [PIXEL_BITS-1:0]               v;
	logic [PIXEL_BITS-1:0]               rda;
	logic [PIXEL_BITS-1:0]               rdb;
	logic [PIXEL_BITS-1:0]               rda_e;
	logic [PIXEL_BITS-1:0]               rdb_e;
	logic signed [shc3_pkg::FILT_BITS-1:0] filt;

	logic                                valid_s1;
	logic [PIXEL_BITS-1:0]               pix_s1;
	logic [CW-1:0]                       col_s1;
	shc3_pkg::pos_flags_t                flags_s1;
	logic                                fwd_s1;
	logic [PIXEL_BITS-1:0]               fwda_s1;
	logic [PIXEL_BITS-1:0]               fwdb_s1;

	logic                                valid_s2;
	shc3_pkg::res_word_t                 word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= shc3_pkg::WIDTH_RESET;
			height_q <= shc3_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (shc3_pkg::reg_idx_t'(wr_index))
				shc3_pkg::REG_IMAGE_WIDTH: begin
					width_q <= wr_data[shc3_pkg::IW_BITS-1:0];
				end
				shc3_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= wr_data[shc3_pkg::IH_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign adv1      = valid_s1 && (!valid_s2 || res_ready);
	assign pix_ready = !valid_s1 || adv1;
	assign accept    = pix_valid && pix_ready;

	assign v = (pix_data.cmd == shc3_pkg::CMD_PIXEL && flags.pass)
		? PIXEL_BITS'(pix_data.pixel[KB-1:0]) : '0;

	shc3_pos #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (wr_en),
		.adv          (accept),
		.image_width  (width_q),
		.image_height (height_q),
		.col          (col),
		.flags        (flags)
	);

	assign rda_e = fwd_s1 ? fwda_s1 : rda;
	assign rdb_e = fwd_s1 ? fwdb_s1 : rdb;

	shc3_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_a (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (rdb_e),
		.re    (accept),
		.raddr (col),
		.rdata (rda)
	);

	shc3_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_b (
		.clk   (clk),
		.we    (adv1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col),
		.rdata (rdb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			flags_s1 <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= adv1 && (col_s1 == col);
			flags_s1 <= flags;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= v;
			col_s1  <= col;
			fwda_s1 <= rdb_e;
			fwdb_s1 <= pix_s1;
		end
	end

	shc3_win #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (adv1),
		.up_in    (rda_e),
		.mid_in   (rdb_e),
		.dn_in    (pix_s1),
		.flags    (flags_s1),
		.filtered (filt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= flags_s1.emit;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			word_s2.filtered     <= filt;
			word_s2.end_of_frame <= flags_s1.eof;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = word_s2;

endmodule
